[rtl/lvpg_pkg.sv]
// ---------------------------------------------------------------------------
// Laser vector point generator package
// Shared widths, codes, command and point records.
// ---------------------------------------------------------------------------
package lvpg_pkg;

  localparam int COORD_W  = 24;
  localparam int FRAC_W   = 8;
  localparam int GAIN_W   = 32;
  localparam int POINT_W  = 16;
  localparam int COLOUR_W = 8;
  localparam int SHIFT    = FRAC_W + 16;
  localparam int PROD_W   = COORD_W + GAIN_W + 1;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * (FRAC_W + 1) + 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam int REG_INDEX_W = 1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << 24;

  typedef enum logic [1:0] {
    ACT_FRAME  = 2'd0,
    ACT_LINE   = 2'd1,
    ACT_VERTEX = 2'd2
  } action_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_X_GAIN = 1'b0,
    REG_Y_GAIN = 1'b1
  } reg_index_t;

  // Point position inside one command: travel from pen, travel to target,
  // drawn first point, drawn second point.
  typedef logic [1:0] step_t;
  localparam step_t STEP_PEN    = 2'd0;
  localparam step_t STEP_TARGET = 2'd1;
  localparam step_t STEP_A      = 2'd2;
  localparam step_t STEP_B      = 2'd3;

  localparam logic [1:0] POLY_IDLE = 2'd0;
  localparam logic [1:0] POLY_ONE  = 2'd1;
  localparam logic [1:0] POLY_SAT  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    logic    travel;
    logic    has_b;
    coord_t  pen_x;
    coord_t  pen_y;
    coord_t  a_x;
    coord_t  a_y;
    coord_t  b_x;
    coord_t  b_y;
    colour_t red;
    colour_t green;
    colour_t blue;
  } cmd_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic                      blanked;
    colour_t                   red;
    colour_t                   green;
    colour_t                   blue;
    logic                      last;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/laser_vector_point_generator_core.sv]
// Drawing items go in through a push/full queue port and scanner points come
// out through an empty/pop queue port, one point per cycle while pop is held
// and points wait. A frame-begin item costs no point, a line two, or four when
// a blanked travel move is inserted, and a polyline vertex none to three (a
// first vertex may take a travel move, a closing vertex repeats the first
// one); the single coordinate-mapping pipeline (multiply, then clamp/offset/
// saturate) emits one point a cycle while the result queue has room, so an
// item's share of output bandwidth is the point count of its command. A
// two-entry command queue lets the input keep accepting while the back end
// drains points. Gains are written through wr_en/wr_index/wr_data; the user
// must do so only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
// Laser vector point generator core
// Top level: gain registers, front end, command queue and back end.
// ---------------------------------------------------------------------------
module laser_vector_point_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic signed [lvpg_pkg::COORD_W-1:0] start_x,
  input  logic signed [lvpg_pkg::COORD_W-1:0] start_y,
  input  logic signed [lvpg_pkg::COORD_W-1:0] end_x,
  input  logic signed [lvpg_pkg::COORD_W-1:0] end_y,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  input  logic                              first_vertex,
  input  logic                              final_vertex,
  input  logic                              closed_shape,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [15:0]                point_x,
  output logic signed [15:0]                point_y,
  output logic                              blanked,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              run_last,
  input  logic                              wr_en,
  input  logic [lvpg_pkg::REG_INDEX_W-1:0]  wr_index,
  input  logic [lvpg_pkg::GAIN_W-1:0]       wr_data
);
  import lvpg_pkg::*;

  logic [GAIN_W-1:0] x_gain, y_gain;
  logic              accept, cmd_push, cmd_pop;
  cmd_t              cmd, head;
  q_status_t         cmdq;
  point_t            point;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_gain <= GAIN_RESET;
      y_gain <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_X_GAIN: x_gain <= wr_data;
        REG_Y_GAIN: y_gain <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign full   = cmdq.full;
  assign accept = push && !cmdq.full;

  lvpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .first_vertex (first_vertex),
    .final_vertex (final_vertex),
    .closed_shape (closed_shape),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  lvpg_cmd_queue u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (cmd),
    .rd     (cmd_pop),
    .head   (head),
    .status (cmdq)
  );

  lvpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .x_gain    (x_gain),
    .y_gain    (y_gain),
    .head      (head),
    .cmd_empty (cmdq.empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .point     (point)
  );

  assign point_x   = point.x;
  assign point_y   = point.y;
  assign blanked   = point.blanked;
  assign out_red   = point.red;
  assign out_green = point.green;
  assign out_blue  = point.blue;
  assign run_last  = point.last;

  // Travel points are always black.
  a_blank_black: assert property (@(posedge clk) disable iff (rst)
    (!empty && blanked) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("blanked point carries colour");

  // Commands only enter a queue with room.
  a_cmd_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmdq.full)
    else $error("command pushed into full queue");

  // Commands only leave a queue holding one.
  a_cmd_pop: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmdq.empty)
    else $error("command popped from empty queue");

  // Leaving reset, both sides come up idle.
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("not idle after reset");

endmodule

[rtl/lvpg_front.sv]
// ---------------------------------------------------------------------------
// Laser vector point generator front end
// Accepts drawing items, tracks pen and polyline state, queues commands.
// ---------------------------------------------------------------------------
module lvpg_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      action,
  input  lvpg_pkg::coord_t start_x,
  input  lvpg_pkg::coord_t start_y,
  input  lvpg_pkg::coord_t end_x,
  input  lvpg_pkg::coord_t end_y,
  input  lvpg_pkg::colour_t red,
  input  lvpg_pkg::colour_t green,
  input  lvpg_pkg::colour_t blue,
  input  logic            first_vertex,
  input  logic            final_vertex,
  input  logic            closed_shape,
  output logic            cmd_push,
  output lvpg_pkg::cmd_t  cmd
);
  import lvpg_pkg::*;

  localparam logic [DIFF_W-1:0] ONE    = DIFF_W'(1) << FRAC_W;
  localparam logic [SQ_W-1:0]   ONE_SQ = SQ_W'(1) << (2 * FRAC_W);

  logic       pen_valid, pen_valid_next;
  coord_t     pen_x, pen_x_next, pen_y, pen_y_next;
  coord_t     poly_first_x, poly_first_x_next, poly_first_y, poly_first_y_next;
  logic [1:0] poly_count, poly_count_next, count_inc;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        adx, ady;
  logic [SQ_W-1:0]          dist_sq;
  logic                     far, emit;

  // Distance from the pen to the new start point.
  always_comb begin
    dx      = DIFF_W'(start_x) - DIFF_W'(pen_x);
    dy      = DIFF_W'(start_y) - DIFF_W'(pen_y);
    adx     = dx[DIFF_W-1] ? -dx : dx;
    ady     = dy[DIFF_W-1] ? -dy : dy;
    dist_sq = SQ_W'(adx[FRAC_W:0]) * SQ_W'(adx[FRAC_W:0])
            + SQ_W'(ady[FRAC_W:0]) * SQ_W'(ady[FRAC_W:0]);
    far     = (adx > ONE) || (ady > ONE) || (dist_sq > ONE_SQ);
  end

  always_comb begin
    pen_valid_next    = pen_valid;
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    poly_first_x_next = poly_first_x;
    poly_first_y_next = poly_first_y;
    poly_count_next   = poly_count;
    count_inc         = (poly_count == POLY_SAT) ? POLY_SAT : poly_count + 2'd1;
    emit              = 1'b0;
    cmd.travel        = 1'b0;
    cmd.has_b         = 1'b0;
    cmd.pen_x         = pen_x;
    cmd.pen_y         = pen_y;
    cmd.a_x           = start_x;
    cmd.a_y           = start_y;
    cmd.b_x           = end_x;
    cmd.b_y           = end_y;
    cmd.red           = red;
    cmd.green         = green;
    cmd.blue          = blue;
    unique case (action_t'(action))
      ACT_FRAME: begin
        pen_valid_next = 1'b0;
        pen_x_next     = '0;
        pen_y_next     = '0;
      end
      ACT_LINE: begin
        emit           = 1'b1;
        cmd.travel     = pen_valid && far;
        cmd.has_b      = 1'b1;
        pen_x_next     = end_x;
        pen_y_next     = end_y;
        pen_valid_next = 1'b1;
      end
      ACT_VERTEX: begin
        if (first_vertex) begin
          poly_first_x_next = start_x;
          poly_first_y_next = start_y;
          if (final_vertex) begin
            poly_count_next = POLY_IDLE;
          end else begin
            poly_count_next = POLY_ONE;
            emit            = 1'b1;
            cmd.travel      = pen_valid && far;
          end
        end else if (poly_count != POLY_IDLE) begin
          emit      = 1'b1;
          cmd.b_x   = poly_first_x;
          cmd.b_y   = poly_first_y;
          if (final_vertex) begin
            // close the shape back to its first vertex
            cmd.has_b       = closed_shape && (count_inc == POLY_SAT);
            pen_x_next      = closed_shape ? poly_first_x : start_x;
            pen_y_next      = closed_shape ? poly_first_y : start_y;
            pen_valid_next  = 1'b1;
            poly_count_next = POLY_IDLE;
          end else begin
            poly_count_next = count_inc;
          end
        end
      end
      default: begin
      end
    endcase
    cmd_push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_valid    <= 1'b0;
      pen_x        <= '0;
      pen_y        <= '0;
      poly_first_x <= '0;
      poly_first_y <= '0;
      poly_count   <= POLY_IDLE;
    end else if (accept) begin
      pen_valid    <= pen_valid_next;
      pen_x        <= pen_x_next;
      pen_y        <= pen_y_next;
      poly_first_x <= poly_first_x_next;
      poly_first_y <= poly_first_y_next;
      poly_count   <= poly_count_next;
    end
  end

endmodule

[rtl/lvpg_cmd_queue.sv]
// ---------------------------------------------------------------------------
// Laser vector point generator command queue
// Short queue of classified commands between front and back ends.
// ---------------------------------------------------------------------------
module lvpg_cmd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  lvpg_pkg::cmd_t       wr_cmd,
  input  logic                 rd,
  output lvpg_pkg::cmd_t       head,
  output lvpg_pkg::q_status_t  status
);
  import lvpg_pkg::*;

  cmd_t                  mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr, rptr;
  logic [CMDQ_CNT_W-1:0] count;

  assign head         = mem[rptr];
  assign status.full  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CMDQ_CNT_W'(wr) - CMDQ_CNT_W'(rd);
    end
  end

endmodule

[rtl/lvpg_back.sv]
// ---------------------------------------------------------------------------
// Laser vector point generator back end
// Steps through each command's points, maps them to scanner coordinates.
// ---------------------------------------------------------------------------
module lvpg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lvpg_pkg::GAIN_W-1:0] x_gain,
  input  logic [lvpg_pkg::GAIN_W-1:0] y_gain,
  input  lvpg_pkg::cmd_t              head,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  logic                        pop,
  output logic                        empty,
  output lvpg_pkg::point_t            point
);
  import lvpg_pkg::*;

  localparam logic signed [PROD_W-1:0] LIM     = PROD_W'(1) << (SHIFT + 17);
  localparam logic signed [PROD_W-1:0] NEG_LIM = -LIM;
  localparam logic signed [PROD_W-1:0] KK      = PROD_W'(32767) << SHIFT;
  localparam logic signed [PROD_W-1:0] BIAS    = (PROD_W'(1) << SHIFT) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] PT_MAX  = PROD_W'(2 ** (POINT_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] PT_MIN  = -PT_MAX - PROD_W'(1);

  // Clamp, offset, truncate toward zero and saturate to 16 bits.
  function automatic logic signed [POINT_W-1:0] map_coord(
    input logic signed [PROD_W-1:0] p,
    input logic                     flip
  );
    logic signed [PROD_W-1:0] c;
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] q;
    c = (p > LIM) ? LIM : ((p < NEG_LIM) ? NEG_LIM : p);
    s = flip ? (KK - c) : (c - KK);
    q = s[PROD_W-1] ? ((s + BIAS) >>> SHIFT) : (s >>> SHIFT);
    if (q > PT_MAX) begin
      return PT_MAX[POINT_W-1:0];
    end else if (q < PT_MIN) begin
      return PT_MIN[POINT_W-1:0];
    end
    return q[POINT_W-1:0];
  endfunction

  step_t  k, e;
  logic   issue, last, blank;
  coord_t sel_x, sel_y;

  logic                     v1;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  point_t                   p1, p2;

  point_t                mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wptr, rptr;
  logic [OUTQ_CNT_W-1:0] ocount;
  logic                  take;

  // Sequencer: pick the next point of the head command.
  always_comb begin
    e     = head.travel ? k : k + STEP_A;
    last  = (e == STEP_B) || ((e == STEP_A) && !head.has_b);
    blank = (e == STEP_PEN) || (e == STEP_TARGET);
    issue = !cmd_empty && ((ocount + OUTQ_CNT_W'(v1)) < OUTQ_CNT_W'(OUTQ_DEPTH));
    unique case (e) inside
      STEP_PEN: begin
        sel_x = head.pen_x;
        sel_y = head.pen_y;
      end
      STEP_TARGET, STEP_A: begin
        sel_x = head.a_x;
        sel_y = head.a_y;
      end
      STEP_B: begin
        sel_x = head.b_x;
        sel_y = head.b_y;
      end
      default: begin
        sel_x = head.a_x;
        sel_y = head.a_y;
      end
    endcase
    cmd_pop = issue && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= STEP_PEN;
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
      if (issue) begin
        k <= last ? STEP_PEN : k + 2'd1;
      end
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_x     <= sel_x * $signed({1'b0, x_gain});
      prod_y     <= sel_y * $signed({1'b0, y_gain});
      p1.x       <= '0;
      p1.y       <= '0;
      p1.blanked <= blank;
      p1.red     <= blank ? '0 : head.red;
      p1.green   <= blank ? '0 : head.green;
      p1.blue    <= blank ? '0 : head.blue;
      p1.last    <= last;
    end
  end

  // Map stage, Y flipped.
  always_comb begin
    p2   = p1;
    p2.x = map_coord(prod_x, 1'b0);
    p2.y = map_coord(prod_y, 1'b1);
  end

  // Result queue.
  assign empty = (ocount == '0);
  assign take  = pop && !empty;
  assign point = mem[rptr];

  always_ff @(posedge clk) begin
    if (v1) begin
      mem[wptr] <= p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      ocount <= '0;
    end else begin
      if (v1) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      ocount <= ocount + OUTQ_CNT_W'(v1) - OUTQ_CNT_W'(take);
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Laser vector point generator testbench
// Drives drawing items through the push/full port and pops scanner points.
// Each popped point is compared with typed points from the table or with the
// points a local copy of the pen, polyline and gain state works out. A short
// table of directed items runs first, then random phases under several gain
// settings, one of them with a long hold-off on the point side.
// ---------------------------------------------------------------------------
module tb_top;
  import lvpg_pkg::*;

  localparam logic [1:0] ACT_RESERVED  = 2'd3;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         HOLD_CYCLES   = 96;
  localparam int         STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [1:0] act;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    colour_t    r;
    colour_t    g;
    colour_t    b;
    logic       fv;
    logic       lv;
    logic       cl;
  } drawing_item_t;

  // typed_n < 0: points come from the local model; otherwise the drawn
  // points typed into the row are expected instead
  typedef struct {
    drawing_item_t       item;
    int                  typed_n;
    logic signed [15:0]  x0;
    logic signed [15:0]  y0;
    logic signed [15:0]  x1;
    logic signed [15:0]  y1;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic [1:0] action;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  colour_t red;
  colour_t green;
  colour_t blue;
  logic first_vertex;
  logic final_vertex;
  logic closed_shape;
  logic empty;
  logic pop;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic blanked;
  colour_t out_red;
  colour_t out_green;
  colour_t out_blue;
  logic run_last;
  logic wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [GAIN_W-1:0] wr_data;

  // local copy of the block state
  logic [GAIN_W-1:0] gain_x;
  logic [GAIN_W-1:0] gain_y;
  logic   pen_known;
  coord_t pen_at_x;
  coord_t pen_at_y;
  coord_t loop_x;
  coord_t loop_y;
  logic [1:0] vertex_cnt;

  point_t     plotted[$];
  point_t     pending_points[$];
  table_row_t stim_table[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         hold_ask = 1'b0;
  bit         hold_done = 1'b0;

  always #4 clk = ~clk;

  laser_vector_point_generator_core DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .red(red),
    .green(green),
    .blue(blue),
    .first_vertex(first_vertex),
    .final_vertex(final_vertex),
    .closed_shape(closed_shape),
    .empty(empty),
    .pop(pop),
    .point_x(point_x),
    .point_y(point_y),
    .blanked(blanked),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .run_last(run_last),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  function automatic longint scale_coord(coord_t c, logic [GAIN_W-1:0] g);
    longint p;
    longint lim;
    p   = longint'(c) * longint'({32'd0, g});
    lim = longint'(1) <<< (SHIFT + 17);
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p;
  endfunction

  // truncate toward zero, then clamp to the scanner range
  function automatic logic signed [15:0] to_scanner(longint s);
    longint q;
    if (s >= 0) q = s >>> SHIFT;
    else q = -((-s) >>> SHIFT);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic point_t map_point(coord_t x, coord_t y, logic blank,
                                       drawing_item_t it);
    point_t p;
    longint k;
    k = longint'(32767) <<< SHIFT;
    p.x       = to_scanner(scale_coord(x, gain_x) - k);
    p.y       = to_scanner(k - scale_coord(y, gain_y));
    p.blanked = blank;
    p.red     = blank ? 8'd0 : it.r;
    p.green   = blank ? 8'd0 : it.g;
    p.blue    = blank ? 8'd0 : it.b;
    p.last    = 1'b0;
    return p;
  endfunction

  // blanked move from the pen to the target when it is more than one unit off
  task automatic add_travel(input coord_t tx, input coord_t ty, input drawing_item_t it);
    longint one;
    longint dx;
    longint dy;
    bit far_away;
    if (!pen_known) return;
    one = longint'(1) <<< FRAC_W;
    dx  = longint'(tx) - longint'(pen_at_x);
    dy  = longint'(ty) - longint'(pen_at_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > one || dy > one) far_away = 1'b1;
    else far_away = (dx * dx + dy * dy) > (one * one);
    if (far_away) begin
      plotted.insert(plotted.size(), map_point(pen_at_x, pen_at_y, 1'b1, it));
      plotted.insert(plotted.size(), map_point(tx, ty, 1'b1, it));
    end
  endtask

  task automatic plot_points(input drawing_item_t it);
    plotted.delete();
    case (it.act)
      ACT_FRAME: begin
        pen_known = 1'b0;
        pen_at_x  = '0;
        pen_at_y  = '0;
      end
      ACT_LINE: begin
        add_travel(it.sx, it.sy, it);
        plotted.insert(plotted.size(), map_point(it.sx, it.sy, 1'b0, it));
        plotted.insert(plotted.size(), map_point(it.ex, it.ey, 1'b0, it));
        pen_at_x  = it.ex;
        pen_at_y  = it.ey;
        pen_known = 1'b1;
      end
      ACT_VERTEX: begin
        if (it.fv) begin
          loop_x = it.sx;
          loop_y = it.sy;
          if (it.lv) begin
            vertex_cnt = POLY_IDLE;
          end else begin
            vertex_cnt = POLY_ONE;
            add_travel(it.sx, it.sy, it);
            plotted.insert(plotted.size(), map_point(it.sx, it.sy, 1'b0, it));
          end
        end else if (vertex_cnt != POLY_IDLE) begin
          if (vertex_cnt != POLY_SAT) vertex_cnt = vertex_cnt + 2'd1;
          plotted.insert(plotted.size(), map_point(it.sx, it.sy, 1'b0, it));
          if (it.lv) begin
            if (it.cl && vertex_cnt == POLY_SAT)
              plotted.insert(plotted.size(), map_point(loop_x, loop_y, 1'b0, it));
            pen_at_x   = it.cl ? loop_x : it.sx;
            pen_at_y   = it.cl ? loop_y : it.sy;
            pen_known  = 1'b1;
            vertex_cnt = POLY_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    if (plotted.size() > 0) begin
      plotted[plotted.size() - 1].last = 1'b1;
    end
  endtask

  function automatic void add_row(input logic [1:0] act, input int sx, input int sy,
                                  input int ex, input int ey, input int r, input int g,
                                  input int b, input int fv, input int lv, input int cl,
                                  input int n, input int x0, input int y0, input int x1,
                                  input int y1);
    table_row_t row;
    row.item.act = act;
    row.item.sx  = coord_t'(sx);
    row.item.sy  = coord_t'(sy);
    row.item.ex  = coord_t'(ex);
    row.item.ey  = coord_t'(ey);
    row.item.r   = colour_t'(r);
    row.item.g   = colour_t'(g);
    row.item.b   = colour_t'(b);
    row.item.fv  = fv[0];
    row.item.lv  = lv[0];
    row.item.cl  = cl[0];
    row.typed_n  = n;
    row.x0 = x0[15:0];
    row.y0 = y0[15:0];
    row.x1 = x1[15:0];
    row.y1 = y1[15:0];
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic table_row_t random_row(input logic [1:0] act);
    table_row_t row;
    row.item.act = act;
    row.item.sx  = coord_t'($urandom);
    row.item.sy  = coord_t'($urandom);
    row.item.ex  = coord_t'($urandom);
    row.item.ey  = coord_t'($urandom);
    row.item.r   = colour_t'($urandom_range(0, 255));
    row.item.g   = colour_t'($urandom_range(0, 255));
    row.item.b   = colour_t'($urandom_range(0, 255));
    row.item.fv  = 1'($urandom_range(0, 1));
    row.item.lv  = 1'($urandom_range(0, 1));
    row.item.cl  = 1'($urandom_range(0, 1));
    row.typed_n  = -1;
    row.x0 = '0;
    row.y0 = '0;
    row.x1 = '0;
    row.y1 = '0;
    return row;
  endfunction

  // pick a coordinate around a base so that travel moves both fire and not
  function automatic coord_t near_coord(input coord_t base);
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'(base + int'($urandom_range(0, 600)) - 300);
      2: return coord_t'(base + ($urandom_range(0, 1) ? 256 : -256)
                         + int'($urandom_range(0, 2)) - 1);
      default: return coord_t'(int'($urandom_range(0, 196608)) - 65536);
    endcase
  endfunction

  task automatic issue_item(input table_row_t row);
    int gap;
    point_t pt;
    gap = 0;
    if (!calm && !(hold_ask && !hold_done) && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    action       <= row.item.act;
    start_x      <= row.item.sx;
    start_y      <= row.item.sy;
    end_x        <= row.item.ex;
    end_y        <= row.item.ey;
    red          <= row.item.r;
    green        <= row.item.g;
    blue         <= row.item.b;
    first_vertex <= row.item.fv;
    final_vertex <= row.item.lv;
    closed_shape <= row.item.cl;
    do @(posedge clk); while (full);
    plot_points(row.item);
    if (row.typed_n >= 0) begin
      plotted.delete();
      for (int k = 0; k < row.typed_n; k++) begin
        pt.x       = (k == 0) ? row.x0 : row.x1;
        pt.y       = (k == 0) ? row.y0 : row.y1;
        pt.blanked = 1'b0;
        pt.red     = row.item.r;
        pt.green   = row.item.g;
        pt.blue    = row.item.b;
        pt.last    = (k == row.typed_n - 1);
        plotted.insert(plotted.size(), pt);
      end
    end
    foreach (plotted[k]) pending_points.insert(pending_points.size(), plotted[k]);
  endtask

  // drop push and wait until every point is out and no item is in flight
  task automatic settle_block();
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy);
    wr_en    <= 1'b1;
    wr_index <= REG_X_GAIN;
    wr_data  <= gx;
    @(posedge clk);
    gain_x = gx;
    wr_index <= REG_Y_GAIN;
    wr_data  <= gy;
    @(posedge clk);
    gain_y = gy;
    wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input bit pressure);
    table_row_t row;
    int sent;
    int len;
    int pick;
    coord_t px;
    coord_t py;
    sent = 0;
    while (sent < n_items) begin
      if (pressure && sent >= 10) hold_ask = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(2, 6);
        px  = pen_at_x;
        py  = pen_at_y;
        for (int v = 0; v < len; v++) begin
          row = random_row(ACT_VERTEX);
          row.item.sx = near_coord(px);
          row.item.sy = near_coord(py);
          row.item.fv = (v == 0);
          row.item.lv = (v == len - 1);
          // now and then restart the polyline or slip a line into it
          if (v > 0 && $urandom_range(0, 19) == 0) row.item.fv = 1'b1;
          if (v > 0 && $urandom_range(0, 19) == 0) issue_item(random_row(ACT_LINE));
          issue_item(row);
          px = row.item.sx;
          py = row.item.sy;
          sent++;
        end
      end else if (pick < 80) begin
        row = random_row(ACT_LINE);
        row.item.sx = near_coord(pen_at_x);
        row.item.sy = near_coord(pen_at_y);
        issue_item(row);
        sent++;
      end else if (pick < 87) begin
        issue_item(random_row(ACT_FRAME));
        sent++;
      end else begin
        // reserved code, stray vertex or single-vertex polyline
        row = random_row($urandom_range(0, 2) == 0 ? ACT_RESERVED : ACT_VERTEX);
        row.item.lv = row.item.fv;
        issue_item(row);
        sent++;
      end
    end
  endtask

  // point side: random stalls, one long hold-off on request, none when calm
  initial begin : receiver
    int stall_left = 0;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && pop && !empty) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", point_x, point_y);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x expected %0d got %0d", want.x, point_x);
          mismatches++;
        end
        if (point_y !== want.y) begin
          $error("point_y expected %0d got %0d", want.y, point_y);
          mismatches++;
        end
        if (blanked !== want.blanked) begin
          $error("blanked expected %0b got %0b", want.blanked, blanked);
          mismatches++;
        end
        if (out_red !== want.red) begin
          $error("out_red expected %0d got %0d", want.red, out_red);
          mismatches++;
        end
        if (out_green !== want.green) begin
          $error("out_green expected %0d got %0d", want.green, out_green);
          mismatches++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue expected %0d got %0d", want.blue, out_blue);
          mismatches++;
        end
        if (run_last !== want.last) begin
          $error("run_last expected %0b got %0b", want.last, run_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rst          <= 1'b1;
    push         <= 1'b0;
    action       <= ACT_FRAME;
    start_x      <= '0;
    start_y      <= '0;
    end_x        <= '0;
    end_y        <= '0;
    red          <= '0;
    green        <= '0;
    blue         <= '0;
    first_vertex <= 1'b0;
    final_vertex <= 1'b0;
    closed_shape <= 1'b0;
    wr_en        <= 1'b0;
    wr_index     <= REG_X_GAIN;
    wr_data      <= '0;
    gain_x     = GAIN_RESET;
    gain_y     = GAIN_RESET;
    pen_known  = 1'b0;
    pen_at_x   = '0;
    pen_at_y   = '0;
    loop_x     = '0;
    loop_y     = '0;
    vertex_cnt = POLY_IDLE;

    // act, start, end, colour, first/final/closed, typed count, typed points
    add_row(ACT_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LINE, 0, 0, 65534, 65534, 255, 0, 128, 0, 0, 0,
            2, -32767, 32767, 32767, -32767);
    // exactly one unit away: no travel; far end clamps on both axes
    add_row(ACT_LINE, 65790, 65534, 8388607, -8388608, 0, 255, 127, 1, 1, 1,
            2, 32767, -32767, 32767, 32767);
    add_row(ACT_LINE, -8388608, 8388607, 0, 0, 18, 52, 86, 0, 0, 0, -1, 0, 0, 0, 0);
    add_row(ACT_FRAME, 0, 0, 0, 0, 255, 255, 255, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(ACT_LINE, 100, 100, 0, 0, 1, 2, 3, 0, 0, 0, 2, -32667, 32667, -32767, 32767);
    add_row(ACT_LINE, 256, 0, 512, 512, 255, 255, 255, 0, 0, 0,
            2, -32511, 32767, -32255, 32255);
    add_row(ACT_LINE, 768, 513, 1000, 1000, 9, 8, 7, 0, 0, 0, -1, 0, 0, 0, 0);
    add_row(ACT_LINE, 1181, 1181, 2000, 2000, 128, 64, 32, 0, 0, 0,
            2, -31586, 31586, -30767, 30767);
    add_row(ACT_LINE, 2182, 2181, 3000, 3000, 0, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0);
    add_row(ACT_RESERVED, 1, 2, 3, 4, 5, 6, 7, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 7, 7, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 5000, 5000, 0, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 6000, 6000, 0, 0, 1, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 4000, 4000, 0, 0, 170, 85, 0, 1, 0, 0, -1, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 4000, 8000, 0, 0, 170, 85, 0, 0, 0, 0, 1, -28767, 24767, 0, 0);
    add_row(ACT_LINE, 10, 10, 20, 20, 3, 2, 1, 1, 0, 1, -1, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 8000, 8000, 0, 0, 170, 85, 0, 0, 0, 0, 1, -24767, 24767, 0, 0);
    add_row(ACT_VERTEX, 8000, 4000, 0, 0, 170, 85, 0, 0, 1, 1,
            2, -24767, 28767, -28767, 28767);
    add_row(ACT_VERTEX, 4100, 4000, 0, 0, 0, 0, 255, 1, 0, 0, 1, -28667, 28767, 0, 0);
    add_row(ACT_VERTEX, -8388608, 8388607, 0, 0, 0, 0, 255, 1, 0, 1, -1, 0, 0, 0, 0);
    // closed but only two vertices: no repeat of the first one
    add_row(ACT_VERTEX, 6000, 6000, 0, 0, 0, 0, 255, 0, 1, 1, 1, -26767, 26767, 0, 0);
    add_row(ACT_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_VERTEX, 0, 0, 0, 0, 255, 255, 0, 1, 0, 0, 1, -32767, 32767, 0, 0);
    add_row(ACT_VERTEX, 131072, -131072, -1, 8388607, 255, 255, 0, 0, 1, 0,
            1, 32767, 32767, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) issue_item(stim_table[i]);
    settle_block();

    write_gains(32'h0001_0000, 32'h0002_0000);
    random_phase(80, 1'b1);
    settle_block();
    write_gains(32'd0, 32'hFFFF_FFFF);
    random_phase(80, 1'b0);
    settle_block();
    write_gains(32'hFFFF_FFFF, 32'd0);
    random_phase(80, 1'b0);
    settle_block();
    write_gains($urandom, $urandom);
    random_phase(80, 1'b0);
    settle_block();
    // final stretch without idling on either side
    calm = 1'b1;
    write_gains(GAIN_RESET, GAIN_RESET);
    random_phase(80, 1'b0);
    settle_block();

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lvpg_pkg.sv
rtl/lvpg_front.sv
rtl/lvpg_cmd_queue.sv
rtl/lvpg_back.sv
rtl/laser_vector_point_generator_core.sv
tb/tb_top.sv
